@@ sv/tps_pkg.sv @@
// Package with shared constants, the prescaler rate table and the transfer payload types.
`default_nettype none

package tps_pkg;

    // Timer input clock and the search limits.
    localparam int unsigned TIMER_CLOCK_HZ  = 2457600;
    localparam int unsigned PRESCALER_COUNT = 7;
    localparam int unsigned COUNT_MAX       = 255;

    // Field widths.
    localparam int unsigned RATE_W  = 20;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned COUNT_W = 8;

    // Divider step counter, one quotient bit per step.
    localparam int unsigned STEP_W    = $clog2(RATE_W);
    localparam int unsigned LAST_STEP = RATE_W - 1;

    // Prescaled clock rate for each prescaler index (divide by 4, 10, 16, 50, 64, 100, 200).
    localparam logic [RATE_W-1:0] BASE_RATE [PRESCALER_COUNT] = '{
        RATE_W'(TIMER_CLOCK_HZ / 4),
        RATE_W'(TIMER_CLOCK_HZ / 10),
        RATE_W'(TIMER_CLOCK_HZ / 16),
        RATE_W'(TIMER_CLOCK_HZ / 50),
        RATE_W'(TIMER_CLOCK_HZ / 64),
        RATE_W'(TIMER_CLOCK_HZ / 100),
        RATE_W'(TIMER_CLOCK_HZ / 200)
    };

    // Index of the first prescaler searched and the last one.
    localparam logic [CODE_W-1:0] FIRST_INDEX = CODE_W'(PRESCALER_COUNT - 1);
    localparam logic [CODE_W-1:0] LAST_INDEX  = '0;

    // Payload of an input transfer.
    typedef struct packed {
        logic [RATE_W-1:0] target_hz;
    } t_in_item;

    // Payload of a result transfer.
    typedef struct packed {
        logic [CODE_W-1:0]  prescale_code;
        logic [COUNT_W-1:0] count_value;
        logic [RATE_W-1:0]  achieved_hz;
    } t_out_item;

endpackage

`default_nettype wire

@@ sv/tps_stream_if.sv @@
// Valid/ready stream interface that carries one payload per transfer.
`default_nettype none

interface tps_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/timer_prescale_divisor_search_core.sv @@
// Top level: timer prescaler and count search with a shared bit-serial divider.
//
//  Port    | Dir | Payload                                   | Transfer when
//  --------+-----+-------------------------------------------+-------------------
//  i_in    | in  | target_hz                                 | valid && ready
//  o_out   | out | prescale_code, count_value, achieved_hz   | valid && ready
//
// Each candidate setting runs the restoring divider (one quotient bit per cycle)
// and then a compare step against the best so far. An item tries up to 7 prescalers
// with counts from 1 to 255, leaving a prescaler once its rate falls below the target.
// The input is ready only while the sequencer is idle; the result is held until
// the output transfer completes. Reset is synchronous and returns the sequencer to idle.
`default_nettype none

module timer_prescale_divisor_search_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tps_stream_if.sink   i_in,
    tps_stream_if.source o_out
);
    import tps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [RATE_W-1:0]   r_target, n_target;
    logic [CODE_W-1:0]   r_idx, n_idx;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [COUNT_W:0]    r_rem, n_rem;
    logic [RATE_W-1:0]   r_quo, n_quo;
    logic                r_best_valid, n_best_valid;
    logic [RATE_W-1:0]   r_best_diff, n_best_diff;
    logic [CODE_W-1:0]   r_best_code, n_best_code;
    logic [COUNT_W-1:0]  r_best_count, n_best_count;
    logic [RATE_W-1:0]   r_best_rate, n_best_rate;

    logic                in_xfer;
    logic                out_xfer;
    logic [COUNT_W:0]    trial;
    logic                trial_fits;
    logic [RATE_W-1:0]   diff;
    logic                rate_below;

    t_in_item            in_item;

    assign in_item  = i_in.payload;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;

    // Handshake and result payload.
    assign i_in.ready                  = (r_state == S_IDLE);
    assign o_out.valid                 = (r_state == S_DONE);
    assign o_out.payload.prescale_code = r_best_code;
    assign o_out.payload.count_value   = r_best_count;
    assign o_out.payload.achieved_hz   = r_best_rate;

    // Restoring divider step: shift in the next dividend bit and try to subtract.
    assign trial      = {r_rem[COUNT_W-1:0], r_quo[RATE_W-1]};
    assign trial_fits = (trial >= {1'b0, r_count});

    // Candidate error; the finished quotient is the candidate rate.
    assign rate_below = (r_quo < r_target);
    assign diff       = rate_below ? (r_target - r_quo) : (r_quo - r_target);

    // Sequencer and datapath next values.
    always_comb begin
        n_state      = r_state;
        n_target     = r_target;
        n_idx        = r_idx;
        n_count      = r_count;
        n_step       = r_step;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_best_valid = r_best_valid;
        n_best_diff  = r_best_diff;
        n_best_code  = r_best_code;
        n_best_count = r_best_count;
        n_best_rate  = r_best_rate;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_target     = in_item.target_hz;
                    n_idx        = FIRST_INDEX;
                    n_count      = COUNT_W'(1);
                    n_step       = '0;
                    n_rem        = '0;
                    n_quo        = BASE_RATE[FIRST_INDEX];
                    n_best_valid = 1'b0;
                    n_best_code  = CODE_W'(1);
                    n_best_count = COUNT_W'(1);
                    n_best_rate  = in_item.target_hz;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = trial_fits ? (trial - {1'b0, r_count}) : trial;
                n_quo = {r_quo[RATE_W-2:0], trial_fits};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(LAST_STEP)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // Keep the earlier candidate on a tie.
                if (!r_best_valid || (diff < r_best_diff)) begin
                    n_best_valid = 1'b1;
                    n_best_diff  = diff;
                    n_best_code  = r_idx + CODE_W'(1);
                    n_best_count = r_count;
                    n_best_rate  = r_quo;
                end
                n_step = '0;
                n_rem  = '0;
                if (rate_below || (r_count == COUNT_W'(COUNT_MAX))) begin
                    if (r_idx == LAST_INDEX) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx - CODE_W'(1);
                        n_count = COUNT_W'(1);
                        n_quo   = BASE_RATE[r_idx - CODE_W'(1)];
                        n_state = S_DIV;
                    end
                end else begin
                    n_count = r_count + COUNT_W'(1);
                    n_quo   = BASE_RATE[r_idx];
                    n_state = S_DIV;
                end
            end
            S_DONE: begin
                if (out_xfer) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; datapath registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target     <= n_target;
        r_idx        <= n_idx;
        r_count      <= n_count;
        r_step       <= n_step;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_best_valid <= n_best_valid;
        r_best_diff  <= n_best_diff;
        r_best_code  <= n_best_code;
        r_best_count <= n_best_count;
        r_best_rate  <= n_best_rate;
    end

    // An accepted item always starts a division.
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_DIV))
        else $error("accepted item did not start a division");

    // The divider never runs past its last quotient bit.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step <= STEP_W'(LAST_STEP)))
        else $error("divider step counter out of range");

    // A result is only offered after at least one candidate was taken as best.
    a_best_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_best_valid)
        else $error("result offered with no candidate recorded");

    // Result code and count lie in their legal ranges.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((r_best_code != '0) && (r_best_count != '0)))
        else $error("result code or count is zero");

    // The remainder stays below the divisor after the last step.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_rem < {1'b0, r_count}))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
